// ===== sv/smmu_pkg.sv =====
// ----------------------------------------------------------------------------
// smmu_pkg - shared types and helpers for the segment table MMU
// Request and status codes, segment types, type derivation and permission
// checks used by the cells and the top level.
// ----------------------------------------------------------------------------
package smmu_pkg;

    localparam int MAX_SEGMENTS_DEF   = 16;
    localparam int PAGE_SHIFT_DEF     = 12;
    localparam int PHYS_ADDR_BITS_DEF = 24;

    localparam logic [31:0] STACK_REGION    = 32'h7f00_0000;
    localparam logic [31:0] FIRST_MAP_RESET = 32'h0804_5000;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_READ  = 2'd2,
        REQ_WRITE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SEG_FAULT  = 2'd1,
        ST_PROT_FAULT = 2'd2,
        ST_MAP_REJECT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEG_RODATA   = 3'd0,
        SEG_RWDATA   = 3'd1,
        SEG_RXCODE   = 3'd2,
        SEG_RWXCODE  = 3'd3,
        SEG_RWSTACK  = 3'd4,
        SEG_RWXSTACK = 3'd5,
        SEG_XOCODE   = 3'd6
    } seg_type_t;

    // control part of a lookup walking the cell row
    typedef struct packed {
        logic        valid;
        logic [1:0]  req;
        logic [31:0] addr;
        logic        stack;
        logic        found;
    } probe_t;

    // segment type from map permission bits and the stack flag
    function automatic logic [2:0] derive_type(input logic r, input logic w,
                                               input logic x, input logic s);
        logic [2:0] ty;
        ty = SEG_RWXSTACK;
        if (!s)
        begin
            if (r && !w && !x) ty = SEG_RODATA;
            if (r &&  w && !x) ty = SEG_RWDATA;
            if (r && !w &&  x) ty = SEG_RXCODE;
            if (r &&  w &&  x) ty = SEG_RWXCODE;
        end
        else if (r && w && !x)
        begin
            ty = SEG_RWSTACK;
        end
        return ty;
    endfunction

    // access permission by segment type
    function automatic logic perm_ok(input logic [1:0] req, input logic [2:0] ty);
        logic ok;
        case (req)
            REQ_FETCH: ok = (ty == SEG_XOCODE) || (ty == SEG_RXCODE) ||
                            (ty == SEG_RWXCODE) || (ty == SEG_RWXSTACK);
            REQ_READ:  ok = (ty != SEG_XOCODE);
            default:   ok = (ty != SEG_RODATA) && (ty != SEG_XOCODE);
        endcase
        return ok;
    endfunction

endpackage

// ===== sv/segment_table_mmu.sv =====
// ----------------------------------------------------------------------------
// segment_table_mmu - base/limit segment MMU
// Maps segments with a bump physical allocator and translates fetch, read
// and write addresses through a row of segment cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  tdata: request fields, tuser: req_type
//  m_axis    out  m_tvalid/m_tready  tdata: result fields, tuser: status
//  cfg       in   cfg_valid/ready    cfg_data: first_map_address
//
//  A map request goes straight into the result register; an access walks
//  the cell row, one cell per cycle, and then into the result register.
//  One request is in flight at a time; s_tready is low while a lookup walks
//  or a result waits on m_tready. Reset clears the segment count, stack
//  slot and allocator; descriptors are meaningless until written.
// ----------------------------------------------------------------------------
module segment_table_mmu #(
    parameter int MAX_SEGMENTS   = smmu_pkg::MAX_SEGMENTS_DEF,
    parameter int PAGE_SHIFT     = smmu_pkg::PAGE_SHIFT_DEF,
    parameter int PHYS_ADDR_BITS = smmu_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] address, [63:32] map_size, [64] allow_read, [65] allow_write,
    // [66] allow_exec, [67] stack_flag, [71:68] zero
    input  logic [71:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] phys_addr, [24] seg_hit, [56:25] seg_base, [88:57] seg_limit,
    // [91:89] seg_type, [95:92] zero
    output logic [95:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PB = PHYS_ADDR_BITS;
    localparam logic [33:0] PMASK = 34'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [33:0] SPACE = 34'(64'd1 << PB);

    // request fields
    logic [31:0] address, map_size;
    logic        allow_read, allow_write, allow_exec, stack_flag;
    assign address     = s_tdata[31:0];
    assign map_size    = s_tdata[63:32];
    assign allow_read  = s_tdata[64];
    assign allow_write = s_tdata[65];
    assign allow_exec  = s_tdata[66];
    assign stack_flag  = s_tdata[67];

    // control state
    logic [CW-1:0] count_reg, count_next;
    logic          stack_valid_reg, stack_valid_next;
    logic [IW-1:0] stack_slot_reg, stack_slot_next;
    logic [31:0]   next_map_reg, next_map_next;
    logic [PB:0]   phys_next_reg, phys_next_next;
    logic          busy_reg, busy_next;
    logic          out_valid_reg, out_valid_next;

    // result register
    logic [1:0]    status_reg, status_next;
    logic [23:0]   paddr_reg, paddr_next;
    logic          hit_reg, hit_next;
    logic [31:0]   base_reg, base_next, limit_reg, limit_next;
    logic [2:0]    type_reg, type_next;

    logic s_acc, cfg_acc, map_acc, look_acc;
    assign s_tready  = !busy_reg && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign map_acc   = s_acc && (s_tuser == smmu_pkg::REQ_MAP);
    assign look_acc  = s_acc && (s_tuser != smmu_pkg::REQ_MAP);

    // map request decode
    logic [33:0]   size_rnd, room;
    logic          map_ok;
    logic [31:0]   map_start, map_lim;
    logic [2:0]    map_type;
    always_comb
    begin
        size_rnd  = ({2'b00, map_size} + PMASK) & ~PMASK;
        room      = SPACE - 34'(phys_next_reg);
        map_ok    = (size_rnd != 34'd0) && (count_reg < CW'(MAX_SEGMENTS)) &&
                    (size_rnd <= room);
        map_start = (address == 32'd0) ? next_map_reg : address;
        map_lim   = map_start + size_rnd[31:0];
        map_type  = smmu_pkg::derive_type(allow_read, allow_write, allow_exec,
                                          stack_flag);
    end

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    assign wr_en  = map_acc && map_ok;
    assign wr_idx = count_reg[IW-1:0];

    // cell row
    smmu_pkg::probe_t        probe   [MAX_SEGMENTS+1];
    logic [31:0]             h_start [MAX_SEGMENTS+1];
    logic [31:0]             h_end   [MAX_SEGMENTS+1];
    logic [2:0]              h_type  [MAX_SEGMENTS+1];
    logic [PB-1:0]           h_phys  [MAX_SEGMENTS+1];

    always_comb
    begin
        probe[0].valid = look_acc;
        probe[0].req   = s_tuser;
        probe[0].addr  = address;
        probe[0].stack = (address & smmu_pkg::STACK_REGION) == smmu_pkg::STACK_REGION;
        probe[0].found = 1'b0;
    end
    assign h_start[0] = '0;
    assign h_end[0]   = '0;
    assign h_type[0]  = '0;
    assign h_phys[0]  = '0;

    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        smmu_cell #(
            .MAX_SEGMENTS  (MAX_SEGMENTS),
            .PHYS_ADDR_BITS(PB),
            .INDEX         (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .seg_count    (count_reg),
            .stack_valid  (stack_valid_reg),
            .stack_slot   (stack_slot_reg),
            .wr_en        (wr_en),
            .wr_idx       (wr_idx),
            .wr_start     (map_start),
            .wr_end       (map_lim),
            .wr_type      (map_type),
            .wr_phys      (phys_next_reg[PB-1:0]),
            .probe_in     (probe[g]),
            .hit_start_in (h_start[g]),
            .hit_end_in   (h_end[g]),
            .hit_type_in  (h_type[g]),
            .hit_phys_in  (h_phys[g]),
            .probe_out    (probe[g+1]),
            .hit_start_out(h_start[g+1]),
            .hit_end_out  (h_end[g+1]),
            .hit_type_out (h_type[g+1]),
            .hit_phys_out (h_phys[g+1])
        );
    end

    // tail of the row: permission and translation
    smmu_pkg::probe_t tail;
    logic [PB-1:0]    xlate;
    logic [PB+23:0]   xlate_wide, mphys_wide;
    assign tail       = probe[MAX_SEGMENTS];
    assign xlate      = h_phys[MAX_SEGMENTS] +
                        PB'(tail.addr - h_start[MAX_SEGMENTS]);
    assign xlate_wide = {24'd0, xlate};
    assign mphys_wide = {24'd0, phys_next_reg[PB-1:0]};

    // next-state logic
    always_comb
    begin
        count_next       = count_reg;
        stack_valid_next = stack_valid_reg;
        stack_slot_next  = stack_slot_reg;
        next_map_next    = next_map_reg;
        phys_next_next   = phys_next_reg;
        busy_next        = busy_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        paddr_next       = paddr_reg;
        hit_next         = hit_reg;
        base_next        = base_reg;
        limit_next       = limit_reg;
        type_next        = type_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        // a register write restarts the map pointer
        if (cfg_acc)
            next_map_next = cfg_data;

        if (look_acc)
            busy_next = 1'b1;

        // map completes at once
        if (map_acc)
        begin
            out_valid_next = 1'b1;
            hit_next       = 1'b0;
            if (map_ok)
            begin
                status_next    = smmu_pkg::ST_OK;
                paddr_next     = mphys_wide[23:0];
                base_next      = map_start;
                limit_next     = map_lim;
                type_next      = map_type;
                count_next     = count_reg + CW'(1);
                next_map_next  = map_lim;
                phys_next_next = phys_next_reg + (PB+1)'(size_rnd);
                if (stack_flag)
                begin
                    stack_valid_next = 1'b1;
                    stack_slot_next  = wr_idx;
                end
            end
            else
            begin
                status_next = smmu_pkg::ST_MAP_REJECT;
                paddr_next  = '0;
                base_next   = '0;
                limit_next  = '0;
                type_next   = '0;
            end
        end

        // lookup leaves the row
        if (tail.valid)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            if (!tail.found)
            begin
                status_next = smmu_pkg::ST_SEG_FAULT;
                paddr_next  = '0;
                hit_next    = 1'b0;
                base_next   = '0;
                limit_next  = '0;
                type_next   = '0;
            end
            else
            begin
                hit_next   = 1'b1;
                base_next  = h_start[MAX_SEGMENTS];
                limit_next = h_end[MAX_SEGMENTS];
                type_next  = h_type[MAX_SEGMENTS];
                if (smmu_pkg::perm_ok(tail.req, h_type[MAX_SEGMENTS]))
                begin
                    status_next = smmu_pkg::ST_OK;
                    paddr_next  = xlate_wide[23:0];
                end
                else
                begin
                    status_next = smmu_pkg::ST_PROT_FAULT;
                    paddr_next  = '0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            stack_valid_reg <= 1'b0;
            stack_slot_reg  <= '0;
            next_map_reg    <= smmu_pkg::FIRST_MAP_RESET;
            phys_next_reg   <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            stack_valid_reg <= stack_valid_next;
            stack_slot_reg  <= stack_slot_next;
            next_map_reg    <= next_map_next;
            phys_next_reg   <= phys_next_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
        hit_reg    <= hit_next;
        base_reg   <= base_next;
        limit_reg  <= limit_next;
        type_reg   <= type_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'd0, type_reg, limit_reg, base_reg, hit_reg, paddr_reg};

    // checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count past table size");
    a_stack_slot: assert property (@(posedge clk) disable iff (!rst_n)
        stack_valid_reg |-> (CW'(stack_slot_reg) < count_reg))
        else $error("stack slot beyond mapped segments");
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && out_valid_reg))
        else $error("lookup in flight with result pending");
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("lookup left row while idle");

endmodule

// ===== sv/smmu_cell.sv =====
// ----------------------------------------------------------------------------
// smmu_cell - one segment slot of the lookup row
// Holds one segment descriptor, compares the passing lookup against it and
// hands the lookup, with the first match so far, to the next cell.
// ----------------------------------------------------------------------------
module smmu_cell #(
    parameter int MAX_SEGMENTS   = smmu_pkg::MAX_SEGMENTS_DEF,
    parameter int PHYS_ADDR_BITS = smmu_pkg::PHYS_ADDR_BITS_DEF,
    parameter int INDEX          = 0,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CW-1:0]             seg_count,
    input  logic                      stack_valid,
    input  logic [IW-1:0]             stack_slot,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_idx,
    input  logic [31:0]               wr_start,
    input  logic [31:0]               wr_end,
    input  logic [2:0]                wr_type,
    input  logic [PHYS_ADDR_BITS-1:0] wr_phys,
    input  smmu_pkg::probe_t          probe_in,
    input  logic [31:0]               hit_start_in,
    input  logic [31:0]               hit_end_in,
    input  logic [2:0]                hit_type_in,
    input  logic [PHYS_ADDR_BITS-1:0] hit_phys_in,
    output smmu_pkg::probe_t          probe_out,
    output logic [31:0]               hit_start_out,
    output logic [31:0]               hit_end_out,
    output logic [2:0]                hit_type_out,
    output logic [PHYS_ADDR_BITS-1:0] hit_phys_out
);

    logic [31:0]               start_reg;
    logic [31:0]               end_reg;
    logic [2:0]                type_reg;
    logic [PHYS_ADDR_BITS-1:0] phys_reg;
    logic                      valid_reg;
    smmu_pkg::probe_t          probe_reg;
    logic [31:0]               hs_reg, he_reg;
    logic [2:0]                ht_reg;
    logic [PHYS_ADDR_BITS-1:0] hp_reg;
    logic                      in_use;
    logic                      match;
    smmu_pkg::probe_t          probe_next;

    // descriptor store, written by the map path
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IW'(INDEX)))
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
            type_reg  <= wr_type;
            phys_reg  <= wr_phys;
        end
    end

    // compare: stack lookups only see the stack slot
    assign in_use = (CW'(INDEX) < seg_count);
    always_comb
    begin
        match = in_use && (probe_in.addr >= start_reg) && (probe_in.addr < end_reg);
        if (probe_in.stack)
            match = match && stack_valid && (stack_slot == IW'(INDEX));
        probe_next       = probe_in;
        probe_next.found = probe_in.found || match;
    end

    // lookup valid travels with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= probe_in.valid;
    end

    // payload hand-off, first match wins
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (!probe_in.found && match)
        begin
            hs_reg <= start_reg;
            he_reg <= end_reg;
            ht_reg <= type_reg;
            hp_reg <= phys_reg;
        end
        else
        begin
            hs_reg <= hit_start_in;
            he_reg <= hit_end_in;
            ht_reg <= hit_type_in;
            hp_reg <= hit_phys_in;
        end
    end

    always_comb
    begin
        probe_out       = probe_reg;
        probe_out.valid = valid_reg;
    end
    assign hit_start_out = hs_reg;
    assign hit_end_out   = he_reg;
    assign hit_type_out  = ht_reg;
    assign hit_phys_out  = hp_reg;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for segment_table_mmu
// Drives map, fetch, read and write words on the request stream. A shadow
// segment table predicts every translation, and each result word is checked
// in order. Runs directed corner cases, table fill, long output stalls and
// a long random mix, with first_map_address rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SEG_SLOTS   = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int WATCH_LIMIT = 4000;

    // one predicted result word
    typedef struct {
        smmu_pkg::status_t status;
        logic [23:0]       phys;
        logic              hit;
        logic [31:0]       base;
        logic [31:0]       limit;
        logic [2:0]        ty;
    } xlate_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // shadow of the block state
    logic [31:0] shadow_start [SEG_SLOTS];
    logic [31:0] shadow_end   [SEG_SLOTS];
    logic [2:0]  shadow_type  [SEG_SLOTS];
    logic [23:0] shadow_phys  [SEG_SLOTS];
    int          shadow_count;
    logic        shadow_stack_ok;
    int          shadow_stack_slot;
    logic [31:0] shadow_next_va;
    longint      shadow_phys_next;

    xlate_t      pending_results [$];
    int          mismatch_count;
    int          result_count;
    int          map_count;
    int          access_count;
    int          fault_count;
    int          reject_count;
    int          idle_cycles;
    int          rx_hold_cycles;
    int          rx_stall;
    bit          burst_mode;

    segment_table_mmu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // permission-derived segment type of a map request
    function automatic logic [2:0] map_type(input logic r, input logic w,
                                            input logic x, input logic s);
        if (!s && r && !w && !x) return smmu_pkg::SEG_RODATA;
        if (!s && r && w && !x)  return smmu_pkg::SEG_RWDATA;
        if (!s && r && !w && x)  return smmu_pkg::SEG_RXCODE;
        if (!s && r && w && x)   return smmu_pkg::SEG_RWXCODE;
        if (s && r && w && !x)   return smmu_pkg::SEG_RWSTACK;
        return smmu_pkg::SEG_RWXSTACK;
    endfunction

    // predicted result of one request; updates the shadow table
    function automatic xlate_t translate_request(input smmu_pkg::req_t req,
            input logic [31:0] addr, input logic [31:0] size,
            input logic r, input logic w, input logic x, input logic s);
        xlate_t      res;
        logic [32:0] rounded;
        logic [31:0] start;
        int          hit_slot;
        logic        ok;
        res = '{smmu_pkg::ST_OK, 24'd0, 1'b0, 32'd0, 32'd0, 3'd0};
        if (req == smmu_pkg::REQ_MAP)
        begin
            rounded = ({1'b0, size} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
            if (rounded == 0 || shadow_count >= SEG_SLOTS ||
                longint'(rounded) > (longint'(1) << 24) - shadow_phys_next)
            begin
                res.status = smmu_pkg::ST_MAP_REJECT;
                return res;
            end
            start = (addr == 0) ? shadow_next_va : addr;
            shadow_start[shadow_count] = start;
            shadow_end[shadow_count]   = start + rounded[31:0];
            shadow_type[shadow_count]  = map_type(r, w, x, s);
            shadow_phys[shadow_count]  = shadow_phys_next[23:0];
            shadow_next_va = start + rounded[31:0];
            if (s)
            begin
                shadow_stack_ok   = 1'b1;
                shadow_stack_slot = shadow_count;
            end
            res.phys  = shadow_phys_next[23:0];
            res.base  = start;
            res.limit = shadow_end[shadow_count];
            res.ty    = shadow_type[shadow_count];
            shadow_phys_next += longint'(rounded);
            shadow_count++;
            return res;
        end
        // access: stack region looks only at the stack segment
        hit_slot = -1;
        if ((addr & smmu_pkg::STACK_REGION) == smmu_pkg::STACK_REGION)
        begin
            if (shadow_stack_ok && addr >= shadow_start[shadow_stack_slot] &&
                addr < shadow_end[shadow_stack_slot])
                hit_slot = shadow_stack_slot;
        end
        else
        begin
            for (int i = 0; i < shadow_count; i++)
                if (hit_slot < 0 && addr >= shadow_start[i] && addr < shadow_end[i])
                    hit_slot = i;
        end
        if (hit_slot < 0)
        begin
            res.status = smmu_pkg::ST_SEG_FAULT;
            return res;
        end
        res.hit   = 1'b1;
        res.base  = shadow_start[hit_slot];
        res.limit = shadow_end[hit_slot];
        res.ty    = shadow_type[hit_slot];
        case (req)
            smmu_pkg::REQ_FETCH: ok = res.ty inside {smmu_pkg::SEG_XOCODE,
                                                     smmu_pkg::SEG_RXCODE,
                                                     smmu_pkg::SEG_RWXCODE,
                                                     smmu_pkg::SEG_RWXSTACK};
            smmu_pkg::REQ_READ:  ok = res.ty != smmu_pkg::SEG_XOCODE;
            default:             ok = res.ty != smmu_pkg::SEG_RODATA &&
                                      res.ty != smmu_pkg::SEG_XOCODE;
        endcase
        if (!ok)
            res.status = smmu_pkg::ST_PROT_FAULT;
        else
            res.phys = shadow_phys[hit_slot] + 24'(addr - shadow_start[hit_slot]);
        return res;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 17);
    endfunction

    // send one request word and queue its predicted result
    task automatic send_request(input smmu_pkg::req_t req, input logic [31:0] addr,
            input logic [31:0] size, input logic r, input logic w,
            input logic x, input logic s);
        int     gap;
        xlate_t res;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'd0, s, x, w, r, size, addr};
        do @(posedge clk); while (!s_tready);
        res = translate_request(req, addr, size, r, w, x, s);
        pending_results.push_back(res);
        if (req == smmu_pkg::REQ_MAP)
        begin
            map_count++;
            if (res.status == smmu_pkg::ST_MAP_REJECT) reject_count++;
        end
        else
        begin
            access_count++;
            if (res.status != smmu_pkg::ST_OK) fault_count++;
        end
    endtask

    task automatic map_seg(input logic [31:0] addr, input logic [31:0] size,
                           input logic [3:0] srxw);
        send_request(smmu_pkg::REQ_MAP, addr, size, srxw[0], srxw[1], srxw[2],
                     srxw[3]);
    endtask

    task automatic access(input smmu_pkg::req_t req, input logic [31:0] addr);
        send_request(req, addr, $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // write first_map_address while idle
    task automatic write_first_map(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_next_va = value;
    endtask

    // random request: mostly hits inside known segments
    task automatic random_request();
        int             pick;
        int             slot;
        logic [31:0]    addr;
        logic [31:0]    span;
        smmu_pkg::req_t req;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            if ($urandom_range(0, 3) == 0)
                map_seg($urandom_range(0, 1) ? 32'd0 : $urandom, $urandom,
                        4'($urandom));
            else
                map_seg($urandom_range(0, 1) ? 32'd0 : $urandom,
                        $urandom_range(1, 32'h30000), 4'($urandom));
            return;
        end
        req = smmu_pkg::req_t'(2'($urandom_range(1, 3)));
        if (pick < 80 && shadow_count > 0)
        begin
            slot = $urandom_range(0, shadow_count - 1);
            span = shadow_end[slot] - shadow_start[slot];
            addr = shadow_start[slot] + ((span == 0) ? 32'd0 : $urandom % span);
            if ($urandom_range(0, 7) == 0)
                addr = $urandom_range(0, 1) ? shadow_end[slot] : shadow_start[slot] - 1;
        end
        else if (pick < 88)
            addr = {1'($urandom), 7'h7f, 24'($urandom)};
        else
            addr = $urandom;
        access(req, addr);
    endtask

    // extremes, every request kind and each fault path
    task automatic test_directed();
        access(smmu_pkg::REQ_READ, 32'h7f00_0000);   // stack address, no stack segment
        access(smmu_pkg::REQ_FETCH, 32'h0000_0000);  // empty table
        map_seg(32'd0, 32'd1, 4'b0001);       // rodata at the default pointer
        map_seg(32'h1234_5000, 32'd0, 4'b0011);   // zero size rejected
        map_seg(32'h1000_0000, 32'h2000, 4'b0011);
        map_seg(32'h2000_0000, 32'h1001, 4'b0101);
        map_seg(32'h3000_0000, 32'h1000, 4'b0111);
        map_seg(32'h7fff_0000, 32'h1_0000, 4'b1011);
        map_seg(32'd0, 32'hffff_ffff, 4'b1111); // larger than physical space
        map_seg(32'h4000_0000, 32'h1000, 4'b0000);
        access(smmu_pkg::REQ_FETCH, 32'h0804_5000);
        access(smmu_pkg::REQ_READ, 32'h0804_5fff);
        access(smmu_pkg::REQ_WRITE, 32'h0804_5000);
        access(smmu_pkg::REQ_WRITE, 32'h1000_1fff);
        access(smmu_pkg::REQ_FETCH, 32'h1000_0000);
        access(smmu_pkg::REQ_FETCH, 32'h2000_1ffc);
        access(smmu_pkg::REQ_WRITE, 32'h2000_0000);
        access(smmu_pkg::REQ_WRITE, 32'h3000_0fff);
        access(smmu_pkg::REQ_READ, 32'h7fff_ffff);
        access(smmu_pkg::REQ_WRITE, 32'h7ffe_ffff);  // stack region below the segment
        access(smmu_pkg::REQ_FETCH, 32'h4000_0000);
        access(smmu_pkg::REQ_READ, 32'h3000_1000);   // just past a limit
        drain();
    endtask

    // pointer extremes, wrapped limits and stack replacement
    task automatic test_map_pointer();
        write_first_map(32'hffff_f000);
        map_seg(32'd0, 32'h2000, 4'b0101);    // limit wraps past zero
        access(smmu_pkg::REQ_READ, 32'hffff_f800);
        access(smmu_pkg::REQ_READ, 32'h0000_0800);
        write_first_map(32'h0000_0000);
        map_seg(32'd0, 32'h1000, 4'b0011);
        access(smmu_pkg::REQ_WRITE, 32'h0000_0010);
        write_first_map(32'hffff_ffff);
        map_seg(32'd0, 32'd1, 4'b0011);
        map_seg(32'h7f00_0000, 32'h1000, 4'b1111); // replaces the stack segment
        access(smmu_pkg::REQ_FETCH, 32'h7f00_0004);
        access(smmu_pkg::REQ_READ, 32'h7fff_0000);
        drain();
    endtask

    // output held off while the sender keeps offering
    task automatic test_backpressure();
        burst_mode = 1'b1;
        rx_hold_cycles = 300;
        repeat (30) random_request();
        burst_mode = 1'b0;
        drain();
    endtask

    // long random mix in phases with a new map pointer each time
    task automatic test_random();
        logic [31:0] first_map;
        for (int phase = 0; phase < 4; phase++)
        begin
            first_map = $urandom;
            write_first_map(first_map);
            for (int n = 0; n < 300; n++)
            begin
                if (n % 60 == 0) burst_mode = 1'($urandom_range(0, 1));
                random_request();
            end
            burst_mode = 1'b0;
        end
        drain();
    endtask

    // result check and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        xlate_t want;
        int     next_stall;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: status %0d data %h",
                                 m_tuser, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[23:0] !== want.phys ||
                        m_tdata[24] !== want.hit || m_tdata[56:25] !== want.base ||
                        m_tdata[88:57] !== want.limit || m_tdata[91:89] !== want.ty)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: want st %0d pa %h hit %0d base %h ",
                                      "lim %h ty %0d, got st %0d pa %h hit %0d ",
                                      "base %h lim %h ty %0d"},
                                     want.status, want.phys, want.hit, want.base,
                                     want.limit, want.ty, m_tuser, m_tdata[23:0],
                                     m_tdata[24], m_tdata[56:25], m_tdata[88:57],
                                     m_tdata[91:89]);
                    end
                end
                rx_stall = burst_mode ? 0 : $urandom_range(0, 17);
            end
            next_stall = rx_stall;
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (next_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || rx_hold_cycles > 0)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = smmu_pkg::REQ_MAP;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        mismatch_count = 0;
        result_count   = 0;
        map_count      = 0;
        access_count   = 0;
        fault_count    = 0;
        reject_count   = 0;
        idle_cycles    = 0;
        rx_hold_cycles = 0;
        burst_mode     = 1'b0;
        shadow_count      = 0;
        shadow_stack_ok   = 1'b0;
        shadow_stack_slot = 0;
        shadow_next_va    = smmu_pkg::FIRST_MAP_RESET;
        shadow_phys_next  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_map_pointer();
        test_backpressure();
        test_random();
        repeat (40) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d results never arrived", pending_results.size());
        end
        $display("covered %0d map requests (%0d rejected) and %0d accesses (%0d faulted)",
                 map_count, reject_count, access_count, fault_count);
        $display("%0d result words checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== segment_table_mmu.f =====
sv/smmu_pkg.sv
sv/smmu_cell.sv
sv/segment_table_mmu.sv
tb/testbench.sv
